FILE: src/s2cd_pkg.sv
// package for the seconds to civil date/time converter
// holds widths, pipeline depths, reciprocal constants and shared struct types
// no dependencies
`timescale 1ns / 1ps

package s2cd_pkg;

   localparam int TIME_W   = 41;
   localparam int OFFSET_W = 25;
   localparam int ZU_W     = 27;
   localparam int SOD_W    = 17;
   localparam int YEAR_W   = 18;

   // register stages in each unit
   localparam int DAYS_STAGES  = 5;
   localparam int DATE_STAGES  = 9;
   localparam int CLOCK_STAGES = 4;
   localparam int HMS_DELAY    = DATE_STAGES - CLOCK_STAGES;

   // csr word index
   localparam logic REG_EPOCH_OFFSET = 1'b0;

   // seconds per day = 128 * 675
   localparam int          DAY_SHIFT = 7;
   localparam logic [9:0]  SOD_DIV   = 10'd675;

   // floor division by 675 is done on a biased, non-negative value
   localparam longint unsigned Q675_BIAS = (64'd1 << 33) / 64'd675 + 64'd1;
   localparam longint unsigned U_BIAS    = Q675_BIAS * 64'd675;

   // era bias keeps the shifted day count positive
   localparam longint unsigned ERA_BIAS     = 64'd256;
   localparam longint unsigned DAYS_PER_ERA = 64'd146097;
   localparam longint unsigned ZU_K =
      64'd719468 + ERA_BIAS * DAYS_PER_ERA - Q675_BIAS;

   // exact reciprocals: shift = dividend bits + ceil(log2 divisor)
   localparam int SH_A = 28;   // 18-bit / 675
   localparam int SH_B = 37;   // 27-bit / 675
   localparam int SH_E = 45;   // 27-bit / 146097
   localparam int SH_H = 29;   // 17-bit / 3600
   localparam int SH_M = 18;   // 12-bit / 60
   localparam int SH_F = 29;   // 18-bit / 1460
   localparam int SH_G = 34;   // 18-bit / 36524
   localparam int SH_Y = 27;   // 18-bit / 365
   localparam int SH_C = 16;   // 9-bit / 100
   localparam int SH_P = 19;   // 11-bit / 153
   localparam int SH_D = 14;   // 11-bit / 5

   localparam longint unsigned RCP_A = ((64'd1 << SH_A) + 64'd674) / 64'd675;
   localparam longint unsigned RCP_B = ((64'd1 << SH_B) + 64'd674) / 64'd675;
   localparam longint unsigned RCP_E = ((64'd1 << SH_E) + 64'd146096) / 64'd146097;
   localparam longint unsigned RCP_H = ((64'd1 << SH_H) + 64'd3599) / 64'd3600;
   localparam longint unsigned RCP_M = ((64'd1 << SH_M) + 64'd59) / 64'd60;
   localparam longint unsigned RCP_F = ((64'd1 << SH_F) + 64'd1459) / 64'd1460;
   localparam longint unsigned RCP_G = ((64'd1 << SH_G) + 64'd36523) / 64'd36524;
   localparam longint unsigned RCP_Y = ((64'd1 << SH_Y) + 64'd364) / 64'd365;
   localparam longint unsigned RCP_C = ((64'd1 << SH_C) + 64'd99) / 64'd100;
   localparam longint unsigned RCP_P = ((64'd1 << SH_P) + 64'd152) / 64'd153;
   localparam longint unsigned RCP_D = ((64'd1 << SH_D) + 64'd4) / 64'd5;

   typedef struct packed {
      logic              valid;
      logic [ZU_W-1:0]   zu;    // days since era origin, biased
      logic [SOD_W-1:0]  sod;   // second of day
   } days_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
   } result_type;

endpackage

FILE: src/s2cd_days.sv
// splits signed seconds into biased day count and second of day
// five register stages; uses s2cd_pkg
`timescale 1ns / 1ps

module s2cd_days import s2cd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic signed [TIME_W-1:0]   time_seconds,
   input  logic signed [OFFSET_W-1:0] offset_days,
   output days_type                   days_out
);

   logic [DAYS_STAGES-1:0] valid_ff, valid_in;

   logic [34:0] u_a_ff, u_a_in;
   logic [6:0]  lo7_a_ff;

   logic [8:0]  q_hi_b_ff, q_hi_b_in;
   logic [17:0] hi_b_ff;
   logic [16:0] lo17_b_ff;
   logic [6:0]  lo7_b_ff;

   logic [26:0] x_c_ff, x_c_in;
   logic [8:0]  q_hi_c_ff;
   logic [6:0]  lo7_c_ff;

   logic [16:0] q_lo_d_ff, q_lo_d_in;
   logic [26:0] x_d_ff;
   logic [8:0]  q_hi_d_ff;
   logic [6:0]  lo7_d_ff;

   logic [ZU_W-1:0]  zu_e_ff, zu_e_in;
   logic [SOD_W-1:0] sod_e_ff, sod_e_in;

   logic [33:0] s1;
   logic [36:0] prod_a;
   logic [17:0] r_hi;
   logic [54:0] prod_b;
   logic [26:0] r_lo;
   logic [25:0] q_u;
   logic [27:0] zu_sum;

   always_comb begin
      valid_in = {valid_ff[DAYS_STAGES-2:0], in_valid};

      // floor by 128 is the arithmetic shift
      s1     = time_seconds[TIME_W-1:DAY_SHIFT];
      u_a_in = {s1[33], s1} + 35'(U_BIAS);

      prod_a    = 37'(u_a_ff[34:17]) * 37'(RCP_A);
      q_hi_b_in = prod_a[SH_A +: 9];

      r_hi   = hi_b_ff - 18'(19'(q_hi_b_ff) * 19'(SOD_DIV));
      x_c_in = {r_hi[9:0], lo17_b_ff};

      prod_b    = 55'(x_c_ff) * 55'(RCP_B);
      q_lo_d_in = prod_b[SH_B +: 17];

      r_lo     = x_d_ff - 27'(27'(q_lo_d_ff) * 27'(SOD_DIV));
      sod_e_in = {r_lo[9:0], lo7_d_ff};
      q_u      = {q_hi_d_ff, q_lo_d_ff};
      zu_sum   = 28'(q_u) + {{3{offset_days[OFFSET_W-1]}}, offset_days} + 28'(ZU_K);
      zu_e_in  = zu_sum[ZU_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_a_ff    <= u_a_in;
         lo7_a_ff  <= time_seconds[DAY_SHIFT-1:0];
         q_hi_b_ff <= q_hi_b_in;
         hi_b_ff   <= u_a_ff[34:17];
         lo17_b_ff <= u_a_ff[16:0];
         lo7_b_ff  <= lo7_a_ff;
         x_c_ff    <= x_c_in;
         q_hi_c_ff <= q_hi_b_ff;
         lo7_c_ff  <= lo7_b_ff;
         q_lo_d_ff <= q_lo_d_in;
         x_d_ff    <= x_c_ff;
         q_hi_d_ff <= q_hi_c_ff;
         lo7_d_ff  <= lo7_c_ff;
         zu_e_ff   <= zu_e_in;
         sod_e_ff  <= sod_e_in;
      end
   end

   assign days_out.valid = valid_ff[DAYS_STAGES-1];
   assign days_out.zu    = zu_e_ff;
   assign days_out.sod   = sod_e_ff;

endmodule

FILE: src/s2cd_clock.sv
// second of day to hour, minute, second, delayed to match the date unit
// uses s2cd_pkg
`timescale 1ns / 1ps

module s2cd_clock import s2cd_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  logic [SOD_W-1:0] sod,
   output logic [4:0]       hour,
   output logic [5:0]       minute,
   output logic [5:0]       second
);

   logic [4:0]       h_1_ff, h_1_in, h_2_ff, h_3_ff, h_4_ff;
   logic [SOD_W-1:0] sod_1_ff;
   logic [11:0]      rs_2_ff, rs_2_in, rs_3_ff;
   logic [5:0]       mi_3_ff, mi_3_in, mi_4_ff;
   logic [5:0]       se_4_ff, se_4_in;
   logic [16:0]      hms_ff [HMS_DELAY];
   logic [16:0]      hms_in [HMS_DELAY];

   logic [34:0] prod_h;
   logic [16:0] rs_full;
   logic [24:0] prod_m;
   logic [11:0] se_full;

   always_comb begin
      prod_h  = 35'(sod) * 35'(RCP_H);
      h_1_in  = prod_h[SH_H +: 5];
      rs_full = sod_1_ff - 17'(17'(h_1_ff) * 17'd3600);
      rs_2_in = rs_full[11:0];
      prod_m  = 25'(rs_2_ff) * 25'(RCP_M);
      mi_3_in = prod_m[SH_M +: 6];
      se_full = rs_3_ff - 12'(12'(mi_3_ff) * 12'd60);
      se_4_in = se_full[5:0];
      hms_in[0] = {h_4_ff, mi_4_ff, se_4_ff};
      for (int i = 1; i < HMS_DELAY; i++) begin
         hms_in[i] = hms_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_1_ff   <= h_1_in;
         sod_1_ff <= sod;
         rs_2_ff  <= rs_2_in;
         h_2_ff   <= h_1_ff;
         mi_3_ff  <= mi_3_in;
         rs_3_ff  <= rs_2_ff;
         h_3_ff   <= h_2_ff;
         se_4_ff  <= se_4_in;
         mi_4_ff  <= mi_3_ff;
         h_4_ff   <= h_3_ff;
         hms_ff   <= hms_in;
      end
   end

   assign hour   = hms_ff[HMS_DELAY-1][16:12];
   assign minute = hms_ff[HMS_DELAY-1][11:6];
   assign second = hms_ff[HMS_DELAY-1][5:0];

endmodule

FILE: src/s2cd_date.sv
// biased day count to proleptic gregorian year, month, day (400-year eras)
// nine register stages, last step combinational; uses s2cd_pkg
`timescale 1ns / 1ps

module s2cd_date import s2cd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [ZU_W-1:0]   zu,
   output logic              out_valid,
   output logic [YEAR_W-1:0] year,
   output logic [3:0]        month,
   output logic [4:0]        day
);

   logic [DATE_STAGES-1:0] valid_ff, valid_in;

   logic [8:0]      era_1_ff, era_1_in, era_2_ff, era_3_ff, era_4_ff, era_5_ff;
   logic [8:0]      era_6_ff, era_7_ff, era_8_ff;
   logic [ZU_W-1:0] zu_1_ff;
   logic [17:0]     doe_2_ff, doe_2_in, doe_3_ff, doe_4_ff, doe_5_ff, doe_6_ff;
   logic [6:0]      c1460_3_ff, c1460_3_in;
   logic [2:0]      c36524_3_ff, c36524_3_in;
   logic            cfull_3_ff, cfull_3_in;
   logic [17:0]     t_4_ff, t_4_in;
   logic [8:0]      yoe_5_ff, yoe_5_in, yoe_6_ff, yoe_7_ff, yoe_8_ff, yoe_9_ff;
   logic [17:0]     yd_6_ff, yd_6_in;
   logic [8:0]      doy_7_ff, doy_7_in, doy_8_ff, doy_9_ff;
   logic [3:0]      mp_8_ff, mp_8_in;
   logic [8:0]      dbase_9_ff, dbase_9_in;
   logic [3:0]      mon_9_ff, mon_9_in;
   logic [18:0]     era400_9_ff, era400_9_in;

   logic [54:0]        prod_e;
   logic [26:0]        doe_full;
   logic [36:0]        prod_f, prod_g, prod_y;
   logic [18:0]        prod_c;
   logic [2:0]         c100;
   logic [10:0]        v_p, w_d;
   logic [22:0]        prod_p, prod_d;
   logic signed [9:0]  era_s;
   logic signed [18:0] era_wide;
   logic [8:0]         day_full;
   logic [18:0]        year_sum;

   always_comb begin
      valid_in = {valid_ff[DATE_STAGES-2:0], in_valid};

      prod_e   = 55'(zu) * 55'(RCP_E);
      era_1_in = prod_e[SH_E +: 9];

      doe_full = zu_1_ff - 27'(27'(era_1_ff) * 27'(DAYS_PER_ERA));
      doe_2_in = doe_full[17:0];

      prod_f      = 37'(doe_2_ff) * 37'(RCP_F);
      c1460_3_in  = prod_f[SH_F +: 7];
      prod_g      = 37'(doe_2_ff) * 37'(RCP_G);
      c36524_3_in = prod_g[SH_G +: 3];
      // last day of the era is the extra leap day of the 400th year
      cfull_3_in  = (doe_2_ff == 18'd146096);

      t_4_in = doe_3_ff - 18'(c1460_3_ff) + 18'(c36524_3_ff) - 18'(cfull_3_ff);

      prod_y   = 37'(t_4_ff) * 37'(RCP_Y);
      yoe_5_in = prod_y[SH_Y +: 9];

      prod_c  = 19'(yoe_5_ff) * 19'(RCP_C);
      c100    = prod_c[SH_C +: 3];
      yd_6_in = 18'(18'(yoe_5_ff) * 18'd365) + 18'(yoe_5_ff[8:2]) - 18'(c100);

      doy_7_in = 9'(doe_6_ff - yd_6_ff);

      v_p     = 11'(11'(doy_7_ff) * 11'd5) + 11'd2;
      prod_p  = 23'(v_p) * 23'(RCP_P);
      mp_8_in = prod_p[SH_P +: 4];

      w_d        = 11'(11'(mp_8_ff) * 11'd153) + 11'd2;
      prod_d     = 23'(w_d) * 23'(RCP_D);
      dbase_9_in = prod_d[SH_D +: 9];
      // march-based month back to january-based
      mon_9_in   = (mp_8_ff < 4'd10) ? mp_8_ff + 4'd3 : mp_8_ff - 4'd9;
      era_s      = $signed({1'b0, era_8_ff}) - 10'sd256;
      era_wide   = 19'(era_s);
      era400_9_in = era_wide * 19'sd400;

      day_full = doy_9_ff - dbase_9_ff + 9'd1;
      year_sum = era400_9_ff + 19'(yoe_9_ff) + 19'(mon_9_ff <= 4'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         era_1_ff    <= era_1_in;
         zu_1_ff     <= zu;
         doe_2_ff    <= doe_2_in;
         era_2_ff    <= era_1_ff;
         c1460_3_ff  <= c1460_3_in;
         c36524_3_ff <= c36524_3_in;
         cfull_3_ff  <= cfull_3_in;
         doe_3_ff    <= doe_2_ff;
         era_3_ff    <= era_2_ff;
         t_4_ff      <= t_4_in;
         doe_4_ff    <= doe_3_ff;
         era_4_ff    <= era_3_ff;
         yoe_5_ff    <= yoe_5_in;
         doe_5_ff    <= doe_4_ff;
         era_5_ff    <= era_4_ff;
         yd_6_ff     <= yd_6_in;
         doe_6_ff    <= doe_5_ff;
         yoe_6_ff    <= yoe_5_ff;
         era_6_ff    <= era_5_ff;
         doy_7_ff    <= doy_7_in;
         yoe_7_ff    <= yoe_6_ff;
         era_7_ff    <= era_6_ff;
         mp_8_ff     <= mp_8_in;
         doy_8_ff    <= doy_7_ff;
         yoe_8_ff    <= yoe_7_ff;
         era_8_ff    <= era_7_ff;
         dbase_9_ff  <= dbase_9_in;
         mon_9_ff    <= mon_9_in;
         era400_9_ff <= era400_9_in;
         doy_9_ff    <= doy_8_ff;
         yoe_9_ff    <= yoe_8_ff;
      end
   end

   assign out_valid = valid_ff[DATE_STAGES-1];
   assign year      = year_sum[YEAR_W-1:0];
   assign month     = mon_9_ff;
   assign day       = day_full[4:0];

endmodule

FILE: src/s2cd_outbuf.sv
// output register with one skid entry; freezes the pipeline only when the skid is full
// uses s2cd_pkg
`timescale 1ns / 1ps

module s2cd_outbuf import s2cd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_res,
   input  logic       out_ready,
   output logic       adv,
   output logic       out_valid,
   output result_type out_res
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff, rsp_res_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_res_ff, skid_res_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_res_in    = rsp_res_ff;
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      if (!rsp_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_res_in    = skid_res_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = in_valid;
            rsp_res_in   = in_res;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_res_in   = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff  <= rsp_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign adv       = !skid_valid_ff;
   assign out_valid = rsp_valid_ff;
   assign out_res   = rsp_res_ff;

endmodule

FILE: src/seconds_to_civil_datetime.sv
// channel    | direction | handshake              | payload
// req        | in        | req_tvalid/req_tready  | time_seconds
// rsp        | out       | rsp_tvalid/rsp_tready  | year, month, day, hour, minute, second
// csr        | in/out    | csr_psel/csr_penable   | epoch_offset_days at word 0
//
// one request per cycle while req_tready is high; a result passes 15 register stages,
// the first loaded at the edge that takes its request (5 day split, 9 calendar, 1 output)
// reset clears every valid bit and the day offset; no clearing pass
// the skid entry fills first on a stall, so req_tready falls only once it is full
// depends on s2cd_pkg, s2cd_days, s2cd_clock, s2cd_date, s2cd_outbuf
`timescale 1ns / 1ps

module seconds_to_civil_datetime import s2cd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // time_seconds[40:0], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // year[17:0], month[21:18], day[26:22],
                                     // hour[31:27], minute[37:32], second[43:38], zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic                       csr_write;
   logic                       adv;
   days_type                   days;
   logic                       date_valid;
   result_type                 res;
   result_type                 rsp_res;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      offset_in = offset_ff;
      if (csr_write && csr_paddr[2] == REG_EPOCH_OFFSET) begin
         offset_in = csr_pwdata[OFFSET_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_EPOCH_OFFSET: csr_prdata = 32'(offset_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   assign req_tready = adv;

   s2cd_days u_days (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_tvalid),
      .time_seconds (req_tdata[TIME_W-1:0]),
      .offset_days  (offset_ff),
      .days_out     (days)
   );

   s2cd_date u_date (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (days.valid),
      .zu        (days.zu),
      .out_valid (date_valid),
      .year      (res.year),
      .month     (res.month),
      .day       (res.day)
   );

   s2cd_clock u_clock (
      .clock  (clock),
      .adv    (adv),
      .sod    (days.sod),
      .hour   (res.hour),
      .minute (res.minute),
      .second (res.second)
   );

   s2cd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (date_valid),
      .in_res    (res),
      .out_ready (rsp_tready),
      .adv       (adv),
      .out_valid (rsp_tvalid),
      .out_res   (rsp_res)
   );

   assign rsp_tdata = {4'd0, rsp_res.second, rsp_res.minute, rsp_res.hour,
                       rsp_res.day, rsp_res.month, rsp_res.year};

endmodule

FILE: src/s2cd_checker.sv
// port-level checks for seconds_to_civil_datetime, bound to the top level
// depends only on the top level's ports
`timescale 1ns / 1ps

module s2cd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // request side only blocks while a result is waiting
   a_block_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request blocked with no result waiting");

   // taking the waiting result frees the request side next cycle
   a_unblock: assert property (@(posedge clock) disable iff (reset)
      !req_tready && rsp_tready |=> req_tready)
      else $error("request side stayed blocked");

   // date and time fields stay in range
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[21:18] >= 4'd1 && rsp_tdata[21:18] <= 4'd12 &&
                     rsp_tdata[26:22] >= 5'd1 && rsp_tdata[31:27] <= 5'd23 &&
                     rsp_tdata[37:32] <= 6'd59 && rsp_tdata[43:38] <= 6'd59 &&
                     rsp_tdata[47:44] == 4'd0)
      else $error("result field out of range");

endmodule

bind seconds_to_civil_datetime s2cd_checker u_s2cd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
